[rtl/stc_pkg.sv]
// types, codes and character helpers shared by the tokenizer files
`timescale 1ns / 1ps

package stc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_LOAD = 2'd2;

   localparam logic [3:0] K_EOF       = 4'd0;
   localparam logic [3:0] K_DIV       = 4'd1;
   localparam logic [3:0] K_LESS      = 4'd2;
   localparam logic [3:0] K_LESSEQ    = 4'd3;
   localparam logic [3:0] K_GREATER   = 4'd4;
   localparam logic [3:0] K_GREATEREQ = 4'd5;
   localparam logic [3:0] K_ASSIGN    = 4'd6;
   localparam logic [3:0] K_EQUAL     = 4'd7;
   localparam logic [3:0] K_STRING    = 4'd8;
   localparam logic [3:0] K_BLOCK     = 4'd9;
   localparam logic [3:0] K_LINE      = 4'd10;
   localparam logic [3:0] K_IDENT     = 4'd11;
   localparam logic [3:0] K_FOR       = 4'd12;
   localparam logic [3:0] K_WHILE     = 4'd13;
   localparam logic [3:0] K_NUMBER    = 4'd14;
   localparam logic [3:0] K_DICT      = 4'd15;

   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_F     = 4'd1;
   localparam logic [3:0] KW_FO    = 4'd2;
   localparam logic [3:0] KW_FOR   = 4'd3;
   localparam logic [3:0] KW_W     = 4'd4;
   localparam logic [3:0] KW_WH    = 4'd5;
   localparam logic [3:0] KW_WHI   = 4'd6;
   localparam logic [3:0] KW_WHIL  = 4'd7;
   localparam logic [3:0] KW_WHILE = 4'd8;
   localparam logic [3:0] KW_DEAD  = 4'd15;

   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;

   localparam logic [7:0] UPPER_LO = 8'd64;
   localparam logic [7:0] UPPER_HI = 8'd91;
   localparam logic [7:0] LOWER_LO = 8'd96;
   localparam logic [7:0] LOWER_HI = 8'd123;

   typedef enum logic [9:0] {
      M_IDLE   = 10'b00_0000_0001,
      M_SLASH  = 10'b00_0000_0010,
      M_LT     = 10'b00_0000_0100,
      M_GT     = 10'b00_0000_1000,
      M_EQ     = 10'b00_0001_0000,
      M_STRING = 10'b00_0010_0000,
      M_BLOCK  = 10'b00_0100_0000,
      M_LINE   = 10'b00_1000_0000,
      M_IDENT  = 10'b01_0000_0000,
      M_NUMBER = 10'b10_0000_0000
   } lex_mode_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_code;
      logic [7:0] class_value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  dict_class;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_payload_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b > UPPER_LO) && (b < UPPER_HI)) || ((b > LOWER_LO) && (b < LOWER_HI));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_0) && (b <= CH_9);
   endfunction

   function automatic logic [3:0] kw_next(input logic [3:0] t, input logic [7:0] b);
      logic [3:0] r;
      r = KW_DEAD;
      if (t == KW_NONE) begin
         if (b == CH_F) r = KW_F;
         else if (b == CH_W) r = KW_W;
      end else if (t == KW_F && b == CH_O) r = KW_FO;
      else if (t == KW_FO && b == CH_R) r = KW_FOR;
      else if (t == KW_W && b == CH_H) r = KW_WH;
      else if (t == KW_WH && b == CH_I) r = KW_WHI;
      else if (t == KW_WHI && b == CH_L) r = KW_WHIL;
      else if (t == KW_WHIL && b == CH_E) r = KW_WHILE;
      return r;
   endfunction

   function automatic logic [3:0] ident_kind(input logic [3:0] t);
      logic [3:0] r;
      r = K_IDENT;
      if (t == KW_FOR) r = K_FOR;
      else if (t == KW_WHILE) r = K_WHILE;
      return r;
   endfunction

endpackage

[rtl/stc_if.sv]
// valid/ready channel interfaces for the tokenizer request and response sides
`timescale 1ns / 1ps

interface stc_req_if;
   logic                     valid;
   logic                     ready;
   stc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stc_rsp_if;
   logic                     valid;
   logic                     ready;
   stc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/script_char_tokenizer.sv]
// streaming tokenizer top level: input register, lexer state, class table, result queue
`timescale 1ns / 1ps

// Takes one transaction per cycle while the result queue has room: a source
// byte, an end-of-input marker or a class table load. Each transaction is
// registered with its class table read, the lexer then handles it and pushes
// zero, one or two tokens into a four-entry result queue. One-token
// transactions sustain one transaction per cycle while the response side
// takes tokens; a two-token one (a token closed by a byte that is itself a
// class token, or end of input after an open token) leaves two entries to
// drain. Tokens reach rsp_bus through the input register and the result
// queue. The class table reads as zero after reset until an entry is loaded;
// a load is visible to the very next byte. Lines, columns and lengths
// saturate at 2^POS_WIDTH-1 and leave on the response side as their low 16 bits.
module script_char_tokenizer #(
   parameter int POS_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   stc_req_if.sink   req_bus,
   stc_rsp_if.source rsp_bus
);
   import stc_pkg::*;

   typedef struct packed {
      logic [3:0]           kind;
      logic [7:0]           cls;
      logic [POS_WIDTH-1:0] line;
      logic [POS_WIDTH-1:0] col;
      logic [POS_WIDTH-1:0] len;
   } tok_rec_type;

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
      return (v == {POS_WIDTH{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] to_out(input logic [POS_WIDTH-1:0] v);
      logic [POS_WIDTH+15:0] ext;
      ext = {16'd0, v};
      return ext[15:0];
   endfunction

   function automatic rsp_payload_type mk_rsp(input tok_rec_type r, input logic last);
      rsp_payload_type p;
      p.token_kind   = r.kind;
      p.dict_class   = r.cls;
      p.start_line   = to_out(r.line);
      p.start_column = to_out(r.col);
      p.token_length = to_out(r.len);
      p.last_of_run  = last;
      return p;
   endfunction

   // input stage
   logic            acc;
   logic            s1_vld_ff;
   req_payload_type s1_req_ff;
   logic            take;
   logic            room;

   // class table
   logic [7:0]             class_mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] class_vld_ff;
   logic [7:0]             class_rd_ff;
   logic                   class_hit_ff;
   logic [7:0]             class_val;

   // lexer state
   lex_mode_type         mode_ff, mode_in;
   logic                 star_ff, star_in;
   logic [3:0]           kw_ff, kw_in;
   logic [POS_WIDTH-1:0] cur_line_ff, cur_line_in;
   logic [POS_WIDTH-1:0] cur_col_ff, cur_col_in;
   logic [POS_WIDTH-1:0] tok_line_ff, tok_line_in;
   logic [POS_WIDTH-1:0] tok_col_ff, tok_col_in;
   logic [POS_WIDTH-1:0] run_ff, run_in;

   // result queue
   rsp_payload_type      fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 pop;

   tok_rec_type          res [2];
   logic [1:0]           n_res;
   logic                 fresh;
   logic [7:0]           b;
   logic [POS_WIDTH-1:0] col;
   logic [POS_WIDTH-1:0] blk_run;

   assign acc           = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign room          = (cnt_ff - {{FIFO_AW{1'b0}}, pop}) <= (FIFO_AW + 1)'(2);
   assign take          = s1_vld_ff && room;
   assign req_bus.ready = !s1_vld_ff || take;
   assign class_val     = class_hit_ff ? class_rd_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (acc) begin
         s1_vld_ff <= 1'b1;
      end else if (take) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_req_ff <= req_bus.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_bus.payload.operation == OP_LOAD) begin
         class_mem_ff[req_bus.payload.char_code] <= req_bus.payload.class_value;
      end
      if (acc) begin
         class_rd_ff <= class_mem_ff[req_bus.payload.char_code];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_vld_ff <= '0;
         class_hit_ff <= 1'b0;
      end else if (acc) begin
         class_hit_ff <= class_vld_ff[req_bus.payload.char_code];
         if (req_bus.payload.operation == OP_LOAD) begin
            class_vld_ff[req_bus.payload.char_code] <= 1'b1;
         end
      end
   end

   always_comb begin
      b           = s1_req_ff.char_code;
      col         = sat_inc(cur_col_ff);
      blk_run     = star_ff ? sat_inc(run_ff) : run_ff;
      mode_in     = mode_ff;
      star_in     = star_ff;
      kw_in       = kw_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      run_in      = run_ff;
      n_res       = 2'd0;
      fresh       = 1'b0;
      res[0]      = '0;
      res[1]      = '0;
      res[0].line = tok_line_ff;
      res[0].col  = tok_col_ff;
      if (take) begin
         unique case (s1_req_ff.operation)
            OP_BYTE: begin
               unique case (mode_ff)
                  M_SLASH: begin
                     if (b == CH_STAR) begin
                        mode_in = M_BLOCK;
                        run_in  = '0;
                        star_in = 1'b0;
                     end else if (b == CH_SLASH) begin
                        mode_in = M_LINE;
                        run_in  = '0;
                     end else begin
                        res[0].kind = K_DIV;
                        res[0].len  = POS_WIDTH'(1);
                        n_res       = 2'd1;
                        fresh       = 1'b1;
                     end
                  end
                  M_LT, M_GT, M_EQ: begin
                     n_res = 2'd1;
                     if (b == CH_EQ) begin
                        res[0].len = POS_WIDTH'(2);
                        mode_in    = M_IDLE;
                        priority case (mode_ff)
                           M_LT:    res[0].kind = K_LESSEQ;
                           M_GT:    res[0].kind = K_GREATEREQ;
                           default: res[0].kind = K_EQUAL;
                        endcase
                     end else begin
                        res[0].len = POS_WIDTH'(1);
                        fresh      = 1'b1;
                        priority case (mode_ff)
                           M_LT:    res[0].kind = K_LESS;
                           M_GT:    res[0].kind = K_GREATER;
                           default: res[0].kind = K_ASSIGN;
                        endcase
                     end
                  end
                  M_STRING: begin
                     if (b == CH_QUOTE) begin
                        res[0].kind = K_STRING;
                        res[0].len  = run_ff;
                        n_res       = 2'd1;
                        mode_in     = M_IDLE;
                     end else begin
                        run_in = sat_inc(run_ff);
                     end
                  end
                  M_BLOCK: begin
                     if (star_ff && b == CH_SLASH) begin
                        res[0].kind = K_BLOCK;
                        res[0].len  = run_ff;
                        n_res       = 2'd1;
                        star_in     = 1'b0;
                        mode_in     = M_IDLE;
                     end else if (b == CH_STAR) begin
                        star_in = 1'b1;
                        run_in  = blk_run;
                     end else begin
                        star_in = 1'b0;
                        run_in  = sat_inc(blk_run);
                     end
                  end
                  M_LINE: begin
                     if (b == CH_LF) begin
                        res[0].kind = K_LINE;
                        res[0].len  = run_ff;
                        n_res       = 2'd1;
                        fresh       = 1'b1;
                     end else begin
                        run_in = sat_inc(run_ff);
                     end
                  end
                  M_IDENT: begin
                     if (is_letter(b) || is_digit(b) || b == CH_UNDER) begin
                        run_in = sat_inc(run_ff);
                        kw_in  = kw_next(kw_ff, b);
                     end else begin
                        res[0].kind = ident_kind(kw_ff);
                        res[0].len  = run_ff;
                        n_res       = 2'd1;
                        fresh       = 1'b1;
                     end
                  end
                  M_NUMBER: begin
                     if (is_digit(b)) begin
                        run_in = sat_inc(run_ff);
                     end else begin
                        res[0].kind = K_NUMBER;
                        res[0].len  = run_ff;
                        n_res       = 2'd1;
                        fresh       = 1'b1;
                     end
                  end
                  M_IDLE: begin
                     fresh = 1'b1;
                  end
                  default: begin
                     fresh = 1'b1;
                  end
               endcase
               if (fresh) begin
                  tok_line_in = cur_line_ff;
                  tok_col_in  = col;
                  run_in      = '0;
                  star_in     = 1'b0;
                  kw_in       = KW_NONE;
                  mode_in     = M_IDLE;
                  if (b == CH_SLASH) begin
                     mode_in = M_SLASH;
                  end else if (b == CH_LT) begin
                     mode_in = M_LT;
                  end else if (b == CH_GT) begin
                     mode_in = M_GT;
                  end else if (b == CH_EQ) begin
                     mode_in = M_EQ;
                  end else if (b == CH_QUOTE) begin
                     mode_in = M_STRING;
                  end else if (is_letter(b) || b == CH_UNDER) begin
                     mode_in = M_IDENT;
                     run_in  = POS_WIDTH'(1);
                     kw_in   = kw_next(KW_NONE, b);
                  end else if (is_digit(b)) begin
                     mode_in = M_NUMBER;
                     run_in  = POS_WIDTH'(1);
                  end else begin
                     res[n_res[0]].kind = K_DICT;
                     res[n_res[0]].cls  = class_val;
                     res[n_res[0]].line = cur_line_ff;
                     res[n_res[0]].col  = col;
                     res[n_res[0]].len  = POS_WIDTH'(1);
                     n_res              = n_res + 2'd1;
                  end
               end
               if (b == CH_LF) begin
                  cur_line_in = sat_inc(cur_line_ff);
                  cur_col_in  = '0;
               end else begin
                  cur_col_in = col;
               end
            end
            OP_END: begin
               n_res      = 2'd1;
               res[0].len = run_ff;
               unique case (mode_ff)
                  M_SLASH: begin
                     res[0].kind = K_DIV;
                     res[0].len  = POS_WIDTH'(1);
                  end
                  M_LT: begin
                     res[0].kind = K_LESS;
                     res[0].len  = POS_WIDTH'(1);
                  end
                  M_GT: begin
                     res[0].kind = K_GREATER;
                     res[0].len  = POS_WIDTH'(1);
                  end
                  M_EQ: begin
                     res[0].kind = K_ASSIGN;
                     res[0].len  = POS_WIDTH'(1);
                  end
                  M_STRING: res[0].kind = K_STRING;
                  M_BLOCK: begin
                     res[0].kind = K_BLOCK;
                     res[0].len  = blk_run;
                  end
                  M_LINE:   res[0].kind = K_LINE;
                  M_IDENT:  res[0].kind = ident_kind(kw_ff);
                  M_NUMBER: res[0].kind = K_NUMBER;
                  default:  n_res = 2'd0;
               endcase
               res[n_res[0]]      = '0;
               res[n_res[0]].kind = K_EOF;
               res[n_res[0]].line = cur_line_ff;
               res[n_res[0]].col  = col;
               n_res              = n_res + 2'd1;
               mode_in            = M_IDLE;
               star_in            = 1'b0;
               kw_in              = KW_NONE;
               cur_line_in        = '0;
               cur_col_in         = '0;
               tok_line_in        = '0;
               tok_col_in         = '0;
               run_in             = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         star_ff     <= 1'b0;
         kw_ff       <= KW_NONE;
         cur_line_ff <= '0;
         cur_col_ff  <= '0;
         tok_line_ff <= '0;
         tok_col_ff  <= '0;
         run_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         star_ff     <= star_in;
         kw_ff       <= kw_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         run_ff      <= run_in;
      end
   end

   // result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(n_res);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      cnt_in    = cnt_ff - {{FIFO_AW{1'b0}}, pop} + (FIFO_AW + 1)'(n_res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= mk_rsp(res[0], n_res == 2'd1);
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= mk_rsp(res[1], 1'b1);
      end
   end

   assign rsp_bus.valid   = cnt_ff != '0;
   assign rsp_bus.payload = fifo_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FIFO_AW + 1)'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      take && s1_req_ff.operation == OP_END |=>
         mode_ff == M_IDLE && cur_line_ff == '0 && cur_col_ff == '0)
      else $error("end of input did not return lexer to idle");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      take && s1_req_ff.operation == OP_END |=> cnt_ff != '0)
      else $error("end of input produced no token");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(mode_ff) && $stable(cur_line_ff) && $stable(cur_col_ff))
      else $error("lexer state moved without a transaction");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      take && s1_req_ff.operation == OP_LOAD |-> n_res == 2'd0)
      else $error("table load produced a token");

endmodule
